// File: hw/rtl/lswc_pkg.sv
// shared types and constants for the line segment window clipper
// no dependencies
package lswc_pkg;

	localparam int unsigned CFG_INDEX_WIDTH = 3;
	localparam int unsigned NUM_BOUNDS      = 4;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_LEFT   = 3'd0,
		REG_RIGHT  = 3'd1,
		REG_BOTTOM = 3'd2,
		REG_TOP    = 3'd3
	} reg_index_t;

	typedef struct packed {
		logic valid;
		logic reject;
	} ctrl_t;

endpackage

// File: hw/rtl/lswc_bound_cell.sv
// one boundary test cell: cross-multiply in the first stage, update entry or exit in the second
// depends on lswc_pkg
module lswc_bound_cell #(
	parameter int unsigned W  = 16,
	parameter int unsigned CW = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  lswc_pkg::ctrl_t      ctrl_i,
	input  logic [CW-1:0]        carry_i,
	input  logic signed [W:0]    p_i,
	input  logic signed [W:0]    q_i,
	input  logic signed [W:0]    en_n_i,
	input  logic [W-1:0]         en_d_i,
	input  logic signed [W:0]    ex_n_i,
	input  logic [W-1:0]         ex_d_i,
	output lswc_pkg::ctrl_t      ctrl_o,
	output logic [CW-1:0]        carry_o,
	output logic signed [W:0]    en_n_o,
	output logic [W-1:0]         en_d_o,
	output logic signed [W:0]    ex_n_o,
	output logic [W-1:0]         ex_d_o
);

	logic              pz, pn;
	logic signed [W:0] n_d, p_neg;
	logic [W-1:0]      d_d, td;
	logic signed [W:0] tn;
	logic signed [2*W+1:0] prod_a_d, prod_b_d;

	lswc_pkg::ctrl_t        ctrl_s1;
	logic [CW-1:0]          carry_s1;
	logic                   pz_s1, pn_s1, qneg_s1;
	logic signed [W:0]      n_s1;
	logic [W-1:0]           d_s1;
	logic signed [2*W+1:0]  prod_a_s1, prod_b_s1;
	logic signed [W:0]      en_n_s1, ex_n_s1;
	logic [W-1:0]           en_d_s1, ex_d_s1;

	lswc_pkg::ctrl_t   ctrl_s2;
	logic [CW-1:0]     carry_s2;
	logic signed [W:0] en_n_s2, ex_n_s2;
	logic [W-1:0]      en_d_s2, ex_d_s2;

	assign pz    = (p_i == '0);
	assign pn    = p_i[W];
	assign p_neg = -p_i;
	assign n_d   = pn ? -q_i : q_i;
	assign d_d   = pn ? p_neg[W-1:0] : p_i[W-1:0];
	assign td    = pn ? en_d_i : ex_d_i;
	assign tn    = pn ? en_n_i : ex_n_i;
	assign prod_a_d = n_d * $signed({1'b0, td});
	assign prod_b_d = tn * $signed({1'b0, d_d});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1 <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			carry_s1  <= carry_i;
			pz_s1     <= pz;
			pn_s1     <= pn;
			qneg_s1   <= q_i[W];
			n_s1      <= n_d;
			d_s1      <= d_d;
			prod_a_s1 <= prod_a_d;
			prod_b_s1 <= prod_b_d;
			en_n_s1   <= en_n_i;
			en_d_s1   <= en_d_i;
			ex_n_s1   <= ex_n_i;
			ex_d_s1   <= ex_d_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s2.valid  <= ctrl_s1.valid;
			ctrl_s2.reject <= ctrl_s1.reject | (pz_s1 & qneg_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			carry_s2 <= carry_s1;
			en_n_s2  <= en_n_s1;
			en_d_s2  <= en_d_s1;
			ex_n_s2  <= ex_n_s1;
			ex_d_s2  <= ex_d_s1;
			if (!pz_s1 && pn_s1 && (prod_a_s1 > prod_b_s1)) begin
				en_n_s2 <= n_s1;
				en_d_s2 <= d_s1;
			end
			if (!pz_s1 && !pn_s1 && (prod_a_s1 < prod_b_s1)) begin
				ex_n_s2 <= n_s1;
				ex_d_s2 <= d_s1;
			end
		end
	end

	assign ctrl_o  = ctrl_s2;
	assign carry_o = carry_s2;
	assign en_n_o  = en_n_s2;
	assign en_d_o  = en_d_s2;
	assign ex_n_o  = ex_n_s2;
	assign ex_d_o  = ex_d_s2;

endmodule

// File: hw/rtl/lswc_div_cell.sv
// one restoring division step: one quotient bit per cell
// no dependencies
module lswc_div_cell #(
	parameter int unsigned W = 16
) (
	input  logic         clk,
	input  logic         adv,
	input  logic [W-1:0] rem_i,
	input  logic [W-1:0] low_i,
	input  logic [W-1:0] quo_i,
	input  logic [W-1:0] den_i,
	output logic [W-1:0] rem_o,
	output logic [W-1:0] low_o,
	output logic [W-1:0] quo_o,
	output logic [W-1:0] den_o
);

	logic [W:0] trial, diff;
	logic       ge;

	logic [W-1:0] rem_s1, low_s1, quo_s1, den_s1;

	assign trial = {rem_i, low_i[W-1]};
	assign diff  = trial - {1'b0, den_i};
	assign ge    = (trial >= {1'b0, den_i});

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s1 <= ge ? diff[W-1:0] : trial[W-1:0];
			low_s1 <= {low_i[W-2:0], 1'b0};
			quo_s1 <= {quo_i[W-2:0], ge};
			den_s1 <= den_i;
		end
	end

	assign rem_o = rem_s1;
	assign low_o = low_s1;
	assign quo_o = quo_s1;
	assign den_o = den_s1;

endmodule

// File: hw/rtl/line_segment_window_clipper_unit.sv
// top level of the line segment window clipper: window registers, boundary cells,
// final interval test, divider cells and output buffer
// depends on lswc_pkg, lswc_bound_cell, lswc_div_cell
//
// channel  direction  signals
// cfg      in         cfg_valid cfg_ready cfg_index cfg_data
// in       in         in_valid in_ready start_x start_y end_x end_y
// out      out        out_valid out_ready visible clipped_start_x/y clipped_end_x/y
//
// one segment per cycle while in_ready is high
// the pipeline holds the entry stage, the four two-stage boundary cells, the interval test
// stages and the divider chain, one quotient bit per cell, ahead of the output register
// reset clears valid state and loads the window to 0, 50, 0, 50
// a result held at the output parks one more in a skid register, then the whole
// pipeline stalls and in_ready falls
module line_segment_window_clipper_unit #(
	parameter int unsigned COORD_WIDTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lswc_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic signed [COORD_WIDTH-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [COORD_WIDTH-1:0]         start_x,
	input  logic signed [COORD_WIDTH-1:0]         start_y,
	input  logic signed [COORD_WIDTH-1:0]         end_x,
	input  logic signed [COORD_WIDTH-1:0]         end_y,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic                                  visible,
	output logic signed [COORD_WIDTH-1:0]         clipped_start_x,
	output logic signed [COORD_WIDTH-1:0]         clipped_start_y,
	output logic signed [COORD_WIDTH-1:0]         clipped_end_x,
	output logic signed [COORD_WIDTH-1:0]         clipped_end_y
);

	localparam int unsigned W  = COORD_WIDTH;
	localparam int unsigned NB = lswc_pkg::NUM_BOUNDS;
	localparam int unsigned CW = 2*W + 6*(W+1);
	localparam int unsigned QB = W + 1;
	localparam int unsigned DY_LO = 4*QB;
	localparam int unsigned DX_LO = 5*QB;
	localparam int unsigned Y1_LO = 6*QB;
	localparam int unsigned X1_LO = 6*QB + W;

	// window registers
	logic signed [W-1:0] left_q, right_q, bottom_q, top_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= W'(0);
			right_q  <= W'(50);
			bottom_q <= W'(0);
			top_q    <= W'(50);
		end else if (cfg_valid && cfg_ready) begin
			unique case (lswc_pkg::reg_index_t'(cfg_index))
				lswc_pkg::REG_LEFT:   left_q   <= cfg_data;
				lswc_pkg::REG_RIGHT:  right_q  <= cfg_data;
				lswc_pkg::REG_BOTTOM: bottom_q <= cfg_data;
				lswc_pkg::REG_TOP:    top_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	logic adv;
	logic skid_v_q;

	assign adv      = !skid_v_q;
	assign in_ready = adv;

	// entry stage
	logic signed [W:0] x1_e, y1_e, dx_e, dy_e, q0_e, q1_e, q2_e, q3_e;

	assign x1_e = $signed({start_x[W-1], start_x});
	assign y1_e = $signed({start_y[W-1], start_y});
	assign dx_e = $signed({end_x[W-1], end_x}) - x1_e;
	assign dy_e = $signed({end_y[W-1], end_y}) - y1_e;
	assign q0_e = x1_e - $signed({left_q[W-1], left_q});
	assign q1_e = $signed({right_q[W-1], right_q}) - x1_e;
	assign q2_e = y1_e - $signed({bottom_q[W-1], bottom_q});
	assign q3_e = $signed({top_q[W-1], top_q}) - y1_e;

	lswc_pkg::ctrl_t ctrl_s1;
	logic [CW-1:0]   carry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (adv) begin
			ctrl_s1.valid  <= in_valid;
			ctrl_s1.reject <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			carry_s1 <= {start_x, start_y, dx_e, dy_e, q3_e, q2_e, q1_e, q0_e};
		end
	end

	// boundary cell chain: left, right, bottom, top
	lswc_pkg::ctrl_t   ctrl_c  [NB+1];
	logic [CW-1:0]     carry_c [NB+1];
	logic signed [W:0] en_n_c  [NB+1];
	logic [W-1:0]      en_d_c  [NB+1];
	logic signed [W:0] ex_n_c  [NB+1];
	logic [W-1:0]      ex_d_c  [NB+1];

	assign ctrl_c[0]  = ctrl_s1;
	assign carry_c[0] = carry_s1;
	assign en_n_c[0]  = '0;
	assign en_d_c[0]  = W'(1);
	assign ex_n_c[0]  = (W+1)'(1);
	assign ex_d_c[0]  = W'(1);

	for (genvar k = 0; k < NB; k++) begin : g_bound
		logic signed [W:0] delta, p, q;

		assign delta = (k < 2) ? carry_c[k][DX_LO +: QB] : carry_c[k][DY_LO +: QB];
		assign p     = (k % 2 == 0) ? -delta : delta;
		assign q     = carry_c[k][k*QB +: QB];

		lswc_bound_cell #(.W(W), .CW(CW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.adv     (adv),
			.ctrl_i  (ctrl_c[k]),
			.carry_i (carry_c[k]),
			.p_i     (p),
			.q_i     (q),
			.en_n_i  (en_n_c[k]),
			.en_d_i  (en_d_c[k]),
			.ex_n_i  (ex_n_c[k]),
			.ex_d_i  (ex_d_c[k]),
			.ctrl_o  (ctrl_c[k+1]),
			.carry_o (carry_c[k+1]),
			.en_n_o  (en_n_c[k+1]),
			.en_d_o  (en_d_c[k+1]),
			.ex_n_o  (ex_n_c[k+1]),
			.ex_d_o  (ex_d_c[k+1])
		);
	end

	// interval test: products, then compare and interpolation products
	lswc_pkg::ctrl_t       ctrl_s2;
	logic signed [2*W+1:0] ax_s2, bx_s2;
	logic [W-1:0]          x1_s2, y1_s2;
	logic signed [W:0]     dx_s2, dy_s2, en_n_s2, ex_n_s2;
	logic [W-1:0]          en_d_s2, ex_d_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (adv) begin
			ctrl_s2 <= ctrl_c[NB];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s2   <= en_n_c[NB] * $signed({1'b0, ex_d_c[NB]});
			bx_s2   <= ex_n_c[NB] * $signed({1'b0, en_d_c[NB]});
			x1_s2   <= carry_c[NB][X1_LO +: W];
			y1_s2   <= carry_c[NB][Y1_LO +: W];
			dx_s2   <= carry_c[NB][DX_LO +: QB];
			dy_s2   <= carry_c[NB][DY_LO +: QB];
			en_n_s2 <= en_n_c[NB];
			ex_n_s2 <= ex_n_c[NB];
			en_d_s2 <= en_d_c[NB];
			ex_d_s2 <= ex_d_c[NB];
		end
	end

	logic signed [W:0] adx_w, ady_w;
	logic [W-1:0]      adx, ady;

	assign adx_w = dx_s2[W] ? -dx_s2 : dx_s2;
	assign ady_w = dy_s2[W] ? -dy_s2 : dy_s2;
	assign adx   = adx_w[W-1:0];
	assign ady   = ady_w[W-1:0];

	lswc_pkg::ctrl_t ctrl_s3;
	logic [2*W-1:0]  prod_s3 [NB];
	logic [W-1:0]    den_s3  [NB];
	logic [W-1:0]    x1_s3, y1_s3;
	logic            sx_s3, sy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (adv) begin
			ctrl_s3.valid  <= ctrl_s2.valid;
			ctrl_s3.reject <= ctrl_s2.reject | (ax_s2 > bx_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3[0] <= en_n_s2[W-1:0] * adx;
			prod_s3[1] <= en_n_s2[W-1:0] * ady;
			prod_s3[2] <= ex_n_s2[W-1:0] * adx;
			prod_s3[3] <= ex_n_s2[W-1:0] * ady;
			den_s3[0]  <= en_d_s2;
			den_s3[1]  <= en_d_s2;
			den_s3[2]  <= ex_d_s2;
			den_s3[3]  <= ex_d_s2;
			x1_s3      <= x1_s2;
			y1_s3      <= y1_s2;
			sx_s3      <= dx_s2[W];
			sy_s3      <= dy_s2[W];
		end
	end

	// divider cell chains, one per coordinate, with a matching delay line
	logic [W-1:0] rem_c [NB][W+1];
	logic [W-1:0] low_c [NB][W+1];
	logic [W-1:0] quo_c [NB][W+1];
	logic [W-1:0] den_c [NB][W+1];

	for (genvar l = 0; l < NB; l++) begin : g_lane
		assign rem_c[l][0] = prod_s3[l][2*W-1:W];
		assign low_c[l][0] = prod_s3[l][W-1:0];
		assign quo_c[l][0] = '0;
		assign den_c[l][0] = den_s3[l];
		for (genvar s = 0; s < W; s++) begin : g_step
			lswc_div_cell #(.W(W)) u_div (
				.clk   (clk),
				.adv   (adv),
				.rem_i (rem_c[l][s]),
				.low_i (low_c[l][s]),
				.quo_i (quo_c[l][s]),
				.den_i (den_c[l][s]),
				.rem_o (rem_c[l][s+1]),
				.low_o (low_c[l][s+1]),
				.quo_o (quo_c[l][s+1]),
				.den_o (den_c[l][s+1])
			);
		end
	end

	lswc_pkg::ctrl_t dctrl_q [W];
	logic [W-1:0]    dx1_q   [W];
	logic [W-1:0]    dy1_q   [W];
	logic            dsx_q   [W];
	logic            dsy_q   [W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < W; i++) begin
				dctrl_q[i] <= '0;
			end
		end else if (adv) begin
			dctrl_q[0] <= ctrl_s3;
			for (int i = 1; i < W; i++) begin
				dctrl_q[i] <= dctrl_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dx1_q[0] <= x1_s3;
			dy1_q[0] <= y1_s3;
			dsx_q[0] <= sx_s3;
			dsy_q[0] <= sy_s3;
			for (int i = 1; i < W; i++) begin
				dx1_q[i] <= dx1_q[i-1];
				dy1_q[i] <= dy1_q[i-1];
				dsx_q[i] <= dsx_q[i-1];
				dsy_q[i] <= dsy_q[i-1];
			end
		end
	end

	// final coordinates
	logic         last_v, last_vis;
	logic [W-1:0] last_c [NB];

	assign last_v   = dctrl_q[W-1].valid;
	assign last_vis = !dctrl_q[W-1].reject;

	for (genvar l = 0; l < NB; l++) begin : g_coord
		logic [W-1:0] base;
		logic         neg;
		logic [W:0]   sum;

		assign base = (l % 2 == 0) ? dx1_q[W-1] : dy1_q[W-1];
		assign neg  = (l % 2 == 0) ? dsx_q[W-1] : dsy_q[W-1];
		assign sum  = neg ? ({1'b0, base} - {1'b0, quo_c[l][W]})
		                  : ({1'b0, base} + {1'b0, quo_c[l][W]});
		assign last_c[l] = last_vis ? sum[W-1:0] : '0;
	end

	// output register and skid register
	logic         out_v_q, out_vis_q, skid_vis_q;
	logic [W-1:0] out_c_q  [NB];
	logic [W-1:0] skid_c_q [NB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_ready || !out_v_q) begin
			out_v_q  <= skid_v_q | (adv & last_v);
			skid_v_q <= 1'b0;
		end else if (adv && last_v) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ready || !out_v_q) begin
			if (skid_v_q) begin
				out_vis_q <= skid_vis_q;
				out_c_q   <= skid_c_q;
			end else begin
				out_vis_q <= last_vis;
				out_c_q   <= last_c;
			end
		end else if (adv && last_v) begin
			skid_vis_q <= last_vis;
			skid_c_q   <= last_c;
		end
	end

	assign out_valid       = out_v_q;
	assign visible         = out_vis_q;
	assign clipped_start_x = out_c_q[0];
	assign clipped_start_y = out_c_q[1];
	assign clipped_end_x   = out_c_q[2];
	assign clipped_end_y   = out_c_q[3];

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !visible) |-> (clipped_start_x == '0 && clipped_start_y == '0 &&
		clipped_end_x == '0 && clipped_end_y == '0))
		else $error("rejected segment with nonzero coordinates");

	a_stall_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !out_ready) |=> skid_v_q && $stable(skid_c_q[0]))
		else $error("skid contents lost while output stalled");

endmodule
